// ===== design/vnui_pkg.sv =====
// ----------------------------------------------------------------------------
// vnui_pkg
// Shared types and constants of the vertex normal index unifier: widths,
// error codes, controller states and the command and status bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package vnui_pkg;

    // Field widths
    localparam int INDEX_W   = 12;
    localparam int NORMAL_W  = 32;
    localparam int BASE_W    = 13;
    localparam int ERR_W     = 2;
    localparam int NRM3_W    = 3 * NORMAL_W;

    // Stream packing
    localparam int S_TDATA_W = 112;
    localparam int M_TDATA_W = 24;
    localparam int M_TUSER_W = 3;

    // Width of the mesh epoch tag kept per slot
    localparam int EPOCH_W   = 8;

    // Error codes
    localparam logic [ERR_W-1:0] ERR_NONE  = 2'd0;
    localparam logic [ERR_W-1:0] ERR_INDEX = 2'd1;
    localparam logic [ERR_W-1:0] ERR_FULL  = 2'd2;

    // Controller states
    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_CLEAR,
        ST_READ,
        ST_DECIDE
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic load_in;
        logic clr_en;
        logic rd_en;
        logic commit;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic epoch_wrap;
        logic clr_last;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

// ===== design/vnui_ctrl.sv =====
// ----------------------------------------------------------------------------
// vnui_ctrl
// Sequencer: boot clear, word accept, optional tag clear on epoch wrap,
// table read and decide/commit into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module vnui_ctrl
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_tvalid,
    input  wire logic              s_tuser,
    output logic                   s_tready,
    input  wire vnui_pkg::status_t status,
    output vnui_pkg::cmd_t         cmd
);

    vnui_pkg::state_t state_reg;
    vnui_pkg::state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= vnui_pkg::ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next  = state_reg;
        s_tready    = 1'b0;
        cmd.load_in = 1'b0;
        cmd.clr_en  = 1'b0;
        cmd.rd_en   = 1'b0;
        cmd.commit  = 1'b0;
        case (state_reg)
            vnui_pkg::ST_INIT:
            begin
                cmd.clr_en = 1'b1;
                if (status.clr_last)
                begin
                    state_next = vnui_pkg::ST_IDLE;
                end
            end
            vnui_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load_in = 1'b1;
                    // mesh start with exhausted epochs needs a tag sweep first
                    if (s_tuser && status.epoch_wrap)
                    begin
                        state_next = vnui_pkg::ST_CLEAR;
                    end
                    else
                    begin
                        state_next = vnui_pkg::ST_READ;
                    end
                end
            end
            vnui_pkg::ST_CLEAR:
            begin
                cmd.clr_en = 1'b1;
                if (status.clr_last)
                begin
                    state_next = vnui_pkg::ST_READ;
                end
            end
            vnui_pkg::ST_READ:
            begin
                cmd.rd_en  = 1'b1;
                state_next = vnui_pkg::ST_DECIDE;
            end
            vnui_pkg::ST_DECIDE:
            begin
                // hold until the output register can take the result
                if (status.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = vnui_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = vnui_pkg::ST_INIT;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== design/vnui_dp.sv =====
// ----------------------------------------------------------------------------
// vnui_dp
// Datapath: input latch, normal and epoch-tag tables, slot counter, the
// claim/match/append decision and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module vnui_dp
#(
    parameter int MAX_VERTICES = 4096
)
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire vnui_pkg::cmd_t                      cmd,
    output vnui_pkg::status_t                        status,
    // s_tdata: vertex_index, normal_x, normal_y, normal_z, zero pad
    input  wire logic [vnui_pkg::S_TDATA_W-1:0]      s_tdata,
    // s_tuser: mesh_start
    input  wire logic                                s_tuser,
    input  wire logic                                cfg_we,
    input  wire logic [vnui_pkg::BASE_W-1:0]         cfg_data,
    input  wire logic                                m_tready,
    output logic                                     m_tvalid,
    // m_tdata: unified_index, source_index
    output logic [vnui_pkg::M_TDATA_W-1:0]           m_tdata,
    // m_tuser: appended, error
    output logic [vnui_pkg::M_TUSER_W-1:0]           m_tuser
);

    localparam int AW    = $clog2(MAX_VERTICES);
    localparam int CNT_W = $clog2(MAX_VERTICES + 1);
    localparam int CMP_W = (CNT_W > vnui_pkg::BASE_W) ? CNT_W : vnui_pkg::BASE_W;
    localparam int IW    = vnui_pkg::INDEX_W;
    localparam int EW    = vnui_pkg::EPOCH_W;
    localparam int NW    = vnui_pkg::NRM3_W;

    // Tables
    logic [NW-1:0] normal_mem [MAX_VERTICES];
    logic [EW-1:0] tag_mem    [MAX_VERTICES];

    // Registers
    logic [IW-1:0]               vi_reg;
    logic [NW-1:0]               normal_reg;
    logic [vnui_pkg::BASE_W-1:0] base_reg;
    logic [CMP_W-1:0]            next_slot_reg;
    logic [CMP_W-1:0]            next_slot_next;
    logic [EW-1:0]               epoch_reg;
    logic [AW-1:0]               clr_addr_reg;
    logic [EW-1:0]               tag_rd_reg;
    logic [NW-1:0]               normal_rd_reg;
    logic                        out_valid_reg;
    logic [IW-1:0]               out_index_reg;
    logic [IW-1:0]               out_src_reg;
    logic                        out_app_reg;
    logic [vnui_pkg::ERR_W-1:0]  out_err_reg;

    // Decision signals
    logic [CMP_W-1:0]            vi_ext;
    logic [AW-1:0]               vi_addr;
    logic                        idx_err;
    logic                        slot_hit;
    logic                        nrm_eq;
    logic                        full;
    logic [IW-1:0]               dec_index;
    logic [IW-1:0]               dec_src;
    logic                        dec_app;
    logic [vnui_pkg::ERR_W-1:0]  dec_err;
    logic                        wr_en;
    logic [AW-1:0]               wr_addr;
    logic                        tag_we;
    logic [AW-1:0]               tag_waddr;
    logic [EW-1:0]               tag_wdata;

    assign vi_ext  = {{(CMP_W-IW){1'b0}}, vi_reg};
    assign vi_addr = vi_ext[AW-1:0];

    // Status to controller
    assign status.epoch_wrap = &epoch_reg;
    assign status.clr_last   = (clr_addr_reg == AW'(MAX_VERTICES - 1));
    assign status.out_free   = !out_valid_reg || m_tready;

    // Input latch
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            vi_reg     <= s_tdata[IW-1:0];
            normal_reg <= s_tdata[IW+NW-1:IW];
        end
    end

    // Base count, slot counter and mesh epoch
    always_comb
    begin
        next_slot_next = next_slot_reg;
        if (cfg_we)
        begin
            next_slot_next = {{(CMP_W-vnui_pkg::BASE_W){1'b0}}, cfg_data};
        end
        else if (cmd.load_in && s_tuser)
        begin
            next_slot_next = {{(CMP_W-vnui_pkg::BASE_W){1'b0}}, base_reg};
        end
        else if (cmd.commit && dec_app)
        begin
            next_slot_next = next_slot_reg + CMP_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg      <= '0;
            next_slot_reg <= '0;
            epoch_reg     <= EW'(1);
        end
        else
        begin
            next_slot_reg <= next_slot_next;
            if (cfg_we)
            begin
                base_reg <= cfg_data;
            end
            if (cmd.load_in && s_tuser)
            begin
                epoch_reg <= status.epoch_wrap ? EW'(1) : epoch_reg + EW'(1);
            end
        end
    end

    // Tag sweep address
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
        end
        else if (cmd.clr_en)
        begin
            clr_addr_reg <= status.clr_last ? '0 : clr_addr_reg + AW'(1);
        end
    end

    // Claim / match / append decision
    always_comb
    begin
        idx_err   = (vi_ext >= {{(CMP_W-vnui_pkg::BASE_W){1'b0}}, base_reg})
                 || (vi_ext >= CMP_W'(MAX_VERTICES));
        slot_hit  = (tag_rd_reg == epoch_reg);
        nrm_eq    = (normal_rd_reg == normal_reg);
        full      = (next_slot_reg >= CMP_W'(MAX_VERTICES));
        dec_index = '0;
        dec_src   = '0;
        dec_app   = 1'b0;
        dec_err   = vnui_pkg::ERR_NONE;
        wr_en     = 1'b0;
        wr_addr   = vi_addr;
        if (idx_err)
        begin
            dec_err = vnui_pkg::ERR_INDEX;
        end
        else if (!slot_hit)
        begin
            // empty slot: claim it
            wr_en     = 1'b1;
            dec_index = vi_reg;
            dec_src   = vi_reg;
        end
        else if (nrm_eq)
        begin
            dec_index = vi_reg;
            dec_src   = vi_reg;
        end
        else if (full)
        begin
            dec_err = vnui_pkg::ERR_FULL;
        end
        else
        begin
            // different normal: append a duplicate slot
            wr_en     = 1'b1;
            wr_addr   = next_slot_reg[AW-1:0];
            dec_index = next_slot_reg[IW-1:0];
            dec_src   = vi_reg;
            dec_app   = 1'b1;
        end
    end

    // Tag write port: sweep clears, commit marks with the current epoch
    always_comb
    begin
        tag_we    = 1'b0;
        tag_waddr = wr_addr;
        tag_wdata = epoch_reg;
        if (cmd.clr_en)
        begin
            tag_we    = 1'b1;
            tag_waddr = clr_addr_reg;
            tag_wdata = '0;
        end
        else if (cmd.commit && wr_en)
        begin
            tag_we = 1'b1;
        end
    end

    // Table writes
    always_ff @(posedge clk)
    begin
        if (tag_we)
        begin
            tag_mem[tag_waddr] <= tag_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit && wr_en)
        begin
            normal_mem[wr_addr] <= normal_reg;
        end
    end

    // Table read, registered
    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            tag_rd_reg    <= tag_mem[vi_addr];
            normal_rd_reg <= normal_mem[vi_addr];
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            out_index_reg <= dec_index;
            out_src_reg   <= dec_src;
            out_app_reg   <= dec_app;
            out_err_reg   <= dec_err;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_src_reg, out_index_reg};
    assign m_tuser  = {out_err_reg, out_app_reg};

endmodule

`default_nettype wire

// ===== design/vertex_normal_index_unifier_top.sv =====
// ----------------------------------------------------------------------------
// vertex_normal_index_unifier_top
// Unifies face-corner vertex indices with per-corner normals, appending
// duplicate vertex slots where a vertex is seen with a different normal.
// ----------------------------------------------------------------------------
//  channel  direction  word                           accepted when
//  s_*      in         corner: index, normal, start   s_tvalid && s_tready
//  m_*      out        unified/source index, flags    m_tvalid && m_tready
//  cfg_*    in         base_vertex_count (13 bits)    cfg_valid && cfg_ready
//
//  Each corner steps through accept, registered table read, decide and write; the next is taken once it is decided.
//  A mesh start on which the 8-bit epoch tag wraps adds a tag sweep over
//  all MAX_VERTICES slots; after reset the same sweep runs with s_tready low.
//  A result waits in the output register; the next corner is accepted and
//  read meanwhile, and only the decide step waits for the output to drain.
//  The configuration channel is always ready.
// ----------------------------------------------------------------------------
`default_nettype none

module vertex_normal_index_unifier_top
#(
    parameter int MAX_VERTICES = 4096
)
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // s_tdata: vertex_index[11:0], normal_x[43:12], normal_y[75:44],
    //          normal_z[107:76], zero pad[111:108]
    input  wire logic [vnui_pkg::S_TDATA_W-1:0]     s_tdata,
    // s_tuser: mesh_start
    input  wire logic                               s_tuser,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // m_tdata: unified_index[11:0], source_index[23:12]
    output logic [vnui_pkg::M_TDATA_W-1:0]          m_tdata,
    // m_tuser: appended[0], error[2:1]
    output logic [vnui_pkg::M_TUSER_W-1:0]          m_tuser,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [vnui_pkg::BASE_W-1:0]        cfg_data
);

    vnui_pkg::cmd_t    cmd;
    vnui_pkg::status_t status;
    logic              cfg_we;

    // Register writes are taken at any time
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    // Controller
    vnui_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Datapath
    vnui_dp
    #(
        .MAX_VERTICES (MAX_VERTICES)
    )
    u_dp
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .status   (status),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire
